// ===== rtl/core/owtr_pkg.sv =====
package owtr_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 10;
  localparam int CountWidth    = 10;

  // register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_PRESENCE_TAIL = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SLOT          = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_RECOVERY      = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_READ_TAIL     = 3'd6;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRAT = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_PRES_WAIT = 4'd2,
    PH_PRES_TAIL = 4'd3,
    PH_WR_SLOT   = 4'd4,
    PH_WR_REC    = 4'd5,
    PH_RD_LOW    = 4'd6,
    PH_RD_SAMPLE = 4'd7,
    PH_RD_TAIL   = 4'd8
  } phase_t;

  // command byte sent at each write step of the sequence
  function automatic logic [7:0] cmd_byte(input logic [1:0] step);
    logic [7:0] b;
    case (step)
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_READ_SCRAT;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/one_wire_temperature_reader.sv =====
// a result is registered into the output register when its item is accepted
// one item per cycle unless the output stalls; the bus sequencer updates on every accepted item
// and the output register frees itself in the same cycle it is taken
// reset (rst, synchronous): sequencer idle, counters and reading cleared,
// timing registers back to their defaults, no result pending
module one_wire_temperature_reader (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   start_req,
  input  logic                                   us_strobe,
  input  logic                                   line_level,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   drive_low,
  output logic                                   busy_res,
  output logic                                   done_res,
  output logic                                   no_device,
  output logic signed [15:0]                     temperature,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [owtr_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [owtr_pkg::CfgDataWidth-1:0]      cfg_data
);

  logic [9:0] reset_low_us;
  logic [7:0] presence_wait_us;
  logic [9:0] presence_tail_us;
  logic [7:0] slot_us;
  logic [3:0] recovery_us;
  logic [3:0] read_sample_us;
  logic [7:0] read_tail_us;

  owtr_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_step, byte_step_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [owtr_pkg::CountWidth-1:0] us_count, us_count_next;
  logic [15:0] shift_word, shift_word_next;
  logic [15:0] last_reading, last_reading_next;
  logic        error_flag, error_flag_next;
  logic        done, drive;

  logic [owtr_pkg::CountWidth-1:0] count_inc;
  logic [owtr_pkg::CountWidth-1:0] target;
  logic        wait_hit;
  logic [7:0]  cur_byte;
  logic        in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us     <= 10'd480;
      presence_wait_us <= 8'd60;
      presence_tail_us <= 10'd240;
      slot_us          <= 8'd60;
      recovery_us      <= 4'd1;
      read_sample_us   <= 4'd1;
      read_tail_us     <= 8'd61;
    end else if (cfg_valid) begin
      case (cfg_index)
        owtr_pkg::REG_RESET_LOW:     reset_low_us     <= cfg_data[9:0];
        owtr_pkg::REG_PRESENCE_WAIT: presence_wait_us <= cfg_data[7:0];
        owtr_pkg::REG_PRESENCE_TAIL: presence_tail_us <= cfg_data[9:0];
        owtr_pkg::REG_SLOT:          slot_us          <= cfg_data[7:0];
        owtr_pkg::REG_RECOVERY:      recovery_us      <= cfg_data[3:0];
        owtr_pkg::REG_READ_SAMPLE:   read_sample_us   <= cfg_data[3:0];
        owtr_pkg::REG_READ_TAIL:     read_tail_us     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // timing target of the wait running in the current phase
  always_comb begin
    case (phase)
      owtr_pkg::PH_RST_LOW:   target = reset_low_us;
      owtr_pkg::PH_PRES_WAIT: target = {2'b00, presence_wait_us};
      owtr_pkg::PH_PRES_TAIL: target = presence_tail_us;
      owtr_pkg::PH_WR_SLOT:   target = {2'b00, slot_us};
      owtr_pkg::PH_WR_REC:    target = {6'd0, recovery_us};
      owtr_pkg::PH_RD_LOW:    target = {6'd0, read_sample_us};
      owtr_pkg::PH_RD_TAIL:   target = {2'b00, read_tail_us};
      default:                target = '0;
    endcase
  end

  assign count_inc = us_count + 1'b1;
  // a zero target ends on the first strobe
  assign wait_hit  = us_strobe & (count_inc >= target);

  always_comb begin
    phase_next        = phase;
    byte_step_next    = byte_step;
    bit_count_next    = bit_count;
    us_count_next     = us_count;
    shift_word_next   = shift_word;
    last_reading_next = last_reading;
    error_flag_next   = error_flag;
    done              = 1'b0;

    if (us_strobe && phase != owtr_pkg::PH_IDLE && phase != owtr_pkg::PH_RD_SAMPLE) begin
      us_count_next = wait_hit ? '0 : count_inc;
    end

    case (phase)
      owtr_pkg::PH_RST_LOW: begin
        if (wait_hit) phase_next = owtr_pkg::PH_PRES_WAIT;
      end
      owtr_pkg::PH_PRES_WAIT: begin
        if (wait_hit) begin
          if (line_level) begin
            error_flag_next = 1'b1;
            done            = 1'b1;
            phase_next      = owtr_pkg::PH_IDLE;
          end else begin
            phase_next = owtr_pkg::PH_PRES_TAIL;
          end
        end
      end
      owtr_pkg::PH_PRES_TAIL: begin
        if (wait_hit) begin
          phase_next     = owtr_pkg::PH_WR_SLOT;
          bit_count_next = '0;
        end
      end
      owtr_pkg::PH_WR_SLOT: begin
        if (wait_hit) phase_next = owtr_pkg::PH_WR_REC;
      end
      owtr_pkg::PH_WR_REC: begin
        if (wait_hit) begin
          bit_count_next = bit_count + 1'b1;
          phase_next     = owtr_pkg::PH_WR_SLOT;
          if (bit_count == 3'd7) begin
            byte_step_next = byte_step + 1'b1;
            if (byte_step_next == 3'd2) phase_next = owtr_pkg::PH_RST_LOW;
            else if (byte_step_next >= 3'd4) phase_next = owtr_pkg::PH_RD_LOW;
          end
        end
      end
      owtr_pkg::PH_RD_LOW: begin
        if (wait_hit) phase_next = owtr_pkg::PH_RD_SAMPLE;
      end
      owtr_pkg::PH_RD_SAMPLE: begin
        shift_word_next = shift_word | (16'(line_level) << {byte_step[0], bit_count});
        us_count_next   = '0;
        phase_next      = owtr_pkg::PH_RD_TAIL;
      end
      owtr_pkg::PH_RD_TAIL: begin
        if (wait_hit) begin
          bit_count_next = bit_count + 1'b1;
          phase_next     = owtr_pkg::PH_RD_LOW;
          if (bit_count == 3'd7) begin
            byte_step_next = byte_step + 1'b1;
            if (byte_step_next >= 3'd6) begin
              last_reading_next = shift_word;
              error_flag_next   = 1'b0;
              done              = 1'b1;
              phase_next        = owtr_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_next = owtr_pkg::PH_IDLE;
        if (start_req) begin
          phase_next      = owtr_pkg::PH_RST_LOW;
          byte_step_next  = '0;
          bit_count_next  = '0;
          us_count_next   = '0;
          shift_word_next = '0;
        end
      end
    endcase
  end

  assign cur_byte = owtr_pkg::cmd_byte(byte_step_next[1:0]);

  // line drive reflects the state after this step
  always_comb begin
    case (phase_next)
      owtr_pkg::PH_RST_LOW, owtr_pkg::PH_RD_LOW: drive = 1'b1;
      owtr_pkg::PH_WR_SLOT: drive = ~cur_byte[bit_count_next] | (us_count_next == '0);
      default: drive = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= owtr_pkg::PH_IDLE;
      byte_step    <= '0;
      bit_count    <= '0;
      us_count     <= '0;
      shift_word   <= '0;
      last_reading <= '0;
      error_flag   <= 1'b0;
    end else if (in_accept) begin
      phase        <= phase_next;
      byte_step    <= byte_step_next;
      bit_count    <= bit_count_next;
      us_count     <= us_count_next;
      shift_word   <= shift_word_next;
      last_reading <= last_reading_next;
      error_flag   <= error_flag_next;
    end
  end

  // output register, refilled on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_low   <= drive;
      busy_res    <= (phase_next != owtr_pkg::PH_IDLE);
      done_res    <= done;
      no_device   <= error_flag_next;
      temperature <= signed'(last_reading_next);
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done pulse while still busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_low |-> busy_res)
    else $error("bus driven low outside a sequence");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == owtr_pkg::PH_IDLE |-> us_count == '0 && bit_count == '0)
    else $error("counters not cleared in idle");

  a_read_only_after_cmds: assert property (@(posedge clk) disable iff (rst)
    phase == owtr_pkg::PH_RD_LOW || phase == owtr_pkg::PH_RD_SAMPLE
      || phase == owtr_pkg::PH_RD_TAIL |-> byte_step >= 3'd4 && byte_step <= 3'd5)
    else $error("read slot outside the read bytes");

  a_temp_on_done: assert property (@(posedge clk) disable iff (rst)
    in_accept && !done |=> last_reading == $past(last_reading))
    else $error("reading changed without a completed sequence");

endmodule
